/* rtl/prt_pkg.sv */
// ----------------------------------------------------------------------------
// prt_pkg
// Shared types and codes for the parent-ready tracker table.
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int SLOT_W = 64;
    localparam int HASH_W = 256;
    localparam int FUNC_W = 3;
    localparam int ERR_W  = 2;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_INIT     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_GENESIS  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SKIP     = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FALLBACK = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_ADD      = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_QUERY    = 3'd5;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_DUP     = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FB_FULL = 2'd2;
    localparam logic [ERR_W-1:0] ERR_RDY_FULL = 2'd3;

    // hash word 0 sits in the top bits, so an unsigned compare orders by bytes
    typedef logic [HASH_W-1:0] hash_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        hash_t             hash;
    } id_t;

    localparam int ID_W = SLOT_W + HASH_W;

    typedef struct packed {
        logic clr;
        logic upd;
    } least_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

endpackage

/* rtl/parent_ready_tracker_table.sv */
// ----------------------------------------------------------------------------
// parent_ready_tracker_table
// Tracks fallback hashes, a skip flag and the least ready parent id.
// ----------------------------------------------------------------------------
// Flow: init, genesis init, skip and query go from idle to decide and done;
//   mark fallback and add ready first pass through scan, walking the entries
//   of their table with one read per cycle, then go to decide and done.
// Throughput: one item at a time; the next is taken once the previous result
//   is registered at the output.
// Reset: clears counts, flags and the least id; tables are not cleared.
// ----------------------------------------------------------------------------
module parent_ready_tracker_table #(
    parameter int TABLE_CAP = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // entry_slot, hash_word0, hash_word1, hash_word2, hash_word3
    input  logic [319:0] s_tdata,
    // func
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // accepted, error_code, parent_ready, best_slot, best_hash_word0,
    // best_hash_word1, best_hash_word2, best_hash_word3, 4 bits zero pad
    output logic [327:0] m_tdata
);

    localparam int CW = $clog2(TABLE_CAP + 1);
    localparam int AW = (TABLE_CAP > 1) ? $clog2(TABLE_CAP) : 1;
    localparam logic [CW-1:0] CAP = CW'(TABLE_CAP);

    prt_pkg::state_t state_reg, state_next;
    logic [prt_pkg::FUNC_W-1:0] func_reg;
    prt_pkg::id_t    item_reg;
    logic [CW-1:0]   fb_cnt_reg, fb_cnt_next;
    logic [CW-1:0]   rdy_cnt_reg, rdy_cnt_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            skip_reg, skip_next;
    logic            dup_reg, dup_next;
    logic            pend_reg;
    logic            acc_reg, acc_next;
    logic [prt_pkg::ERR_W-1:0] err_reg, err_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [327:0]    m_tdata_reg;

    logic            take;
    logic            use_fb;
    logic [CW-1:0]   scan_cnt;
    logic            issue;
    logic            load_out;
    logic            fb_wr_en, rdy_wr_en;
    logic [AW-1:0]   fb_wr_addr;
    prt_pkg::hash_t  fb_wr_data;
    logic            fb_match, rdy_match;
    prt_pkg::least_ctl_t least_ctl;
    prt_pkg::id_t    least;
    logic            ready_flag;
    logic            decide;

    assign s_tready = (state_reg == prt_pkg::ST_IDLE);
    assign take     = s_tvalid && s_tready;
    assign use_fb   = (func_reg == prt_pkg::FUNC_FALLBACK);
    assign scan_cnt = use_fb ? fb_cnt_reg : rdy_cnt_reg;
    assign issue    = (state_reg == prt_pkg::ST_SCAN) && (idx_reg < scan_cnt);
    assign decide   = (state_reg == prt_pkg::ST_DECIDE);
    assign load_out = (state_reg == prt_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next   = state_reg;
        fb_cnt_next  = fb_cnt_reg;
        rdy_cnt_next = rdy_cnt_reg;
        idx_next     = idx_reg;
        skip_next    = skip_reg;
        dup_next     = dup_reg | fb_match | rdy_match;
        acc_next     = acc_reg;
        err_next     = err_reg;
        fb_wr_en     = 1'b0;
        fb_wr_addr   = fb_cnt_reg[AW-1:0];
        fb_wr_data   = item_reg.hash;
        rdy_wr_en    = 1'b0;
        least_ctl    = '0;
        m_tvalid_next = (m_tvalid_reg && !m_tready) || load_out;

        case (state_reg)
            prt_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    idx_next = '0;
                    dup_next = 1'b0;
                    if ((s_tuser == prt_pkg::FUNC_FALLBACK) || (s_tuser == prt_pkg::FUNC_ADD))
                    begin
                        state_next = prt_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = prt_pkg::ST_DECIDE;
                    end
                end
            end
            prt_pkg::ST_SCAN:
            begin
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = prt_pkg::ST_DECIDE;
                end
            end
            prt_pkg::ST_DECIDE:
            begin
                // writes land here only; no scan read overlaps them
                acc_next   = 1'b0;
                err_next   = prt_pkg::ERR_NONE;
                state_next = prt_pkg::ST_DONE;
                case (func_reg)
                    prt_pkg::FUNC_INIT:
                    begin
                        skip_next     = 1'b0;
                        fb_cnt_next   = '0;
                        rdy_cnt_next  = '0;
                        least_ctl.clr = 1'b1;
                    end
                    prt_pkg::FUNC_GENESIS:
                    begin
                        skip_next     = 1'b0;
                        rdy_cnt_next  = '0;
                        least_ctl.clr = 1'b1;
                        fb_wr_en      = 1'b1;
                        fb_wr_addr    = '0;
                        fb_wr_data    = '0;
                        fb_cnt_next   = CW'(1);
                    end
                    prt_pkg::FUNC_SKIP:
                    begin
                        if (!skip_reg)
                        begin
                            skip_next = 1'b1;
                            acc_next  = 1'b1;
                        end
                    end
                    prt_pkg::FUNC_FALLBACK:
                    begin
                        if (!dup_reg)
                        begin
                            if (fb_cnt_reg == CAP)
                            begin
                                err_next = prt_pkg::ERR_FB_FULL;
                            end
                            else
                            begin
                                fb_wr_en    = 1'b1;
                                fb_cnt_next = fb_cnt_reg + 1'b1;
                                acc_next    = 1'b1;
                            end
                        end
                    end
                    prt_pkg::FUNC_ADD:
                    begin
                        if (dup_reg)
                        begin
                            err_next = prt_pkg::ERR_DUP;
                        end
                        else if (rdy_cnt_reg == CAP)
                        begin
                            err_next = prt_pkg::ERR_RDY_FULL;
                        end
                        else
                        begin
                            rdy_wr_en     = 1'b1;
                            rdy_cnt_next  = rdy_cnt_reg + 1'b1;
                            least_ctl.upd = 1'b1;
                            acc_next      = 1'b1;
                        end
                    end
                    prt_pkg::FUNC_QUERY:
                    begin
                        acc_next = ready_flag;
                    end
                    default:
                    begin
                        acc_next = 1'b0;
                    end
                endcase
            end
            prt_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = prt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = prt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= prt_pkg::ST_IDLE;
            fb_cnt_reg   <= '0;
            rdy_cnt_reg  <= '0;
            idx_reg      <= '0;
            skip_reg     <= 1'b0;
            dup_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            acc_reg      <= 1'b0;
            err_reg      <= prt_pkg::ERR_NONE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fb_cnt_reg   <= fb_cnt_next;
            rdy_cnt_reg  <= rdy_cnt_next;
            idx_reg      <= idx_next;
            skip_reg     <= skip_next;
            dup_reg      <= dup_next;
            pend_reg     <= issue;
            acc_reg      <= acc_next;
            err_reg      <= err_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            func_reg      <= s_tuser;
            item_reg.slot <= s_tdata[63:0];
            item_reg.hash <= {s_tdata[127:64], s_tdata[191:128],
                              s_tdata[255:192], s_tdata[319:256]};
        end
        if (load_out)
        begin
            m_tdata_reg <= {4'b0000,
                            least.hash[63:0], least.hash[127:64],
                            least.hash[191:128], least.hash[255:192],
                            least.slot, ready_flag, err_reg, acc_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    prt_table #(
        .WIDTH (prt_pkg::HASH_W),
        .DEPTH (TABLE_CAP),
        .AW    (AW)
    ) u_fb_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fb_wr_en),
        .wr_addr (fb_wr_addr),
        .wr_data (fb_wr_data),
        .rd_en   (issue && use_fb),
        .rd_addr (idx_reg[AW-1:0]),
        .key     (item_reg.hash),
        .match   (fb_match)
    );

    prt_table #(
        .WIDTH (prt_pkg::ID_W),
        .DEPTH (TABLE_CAP),
        .AW    (AW)
    ) u_rdy_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rdy_wr_en),
        .wr_addr (rdy_cnt_reg[AW-1:0]),
        .wr_data (item_reg),
        .rd_en   (issue && !use_fb),
        .rd_addr (idx_reg[AW-1:0]),
        .key     (item_reg),
        .match   (rdy_match)
    );

    prt_least u_least (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (least_ctl),
        .key        (item_reg),
        .least      (least),
        .ready_flag (ready_flag)
    );

endmodule

/* rtl/prt_table.sv */
// ----------------------------------------------------------------------------
// prt_table
// Single-port-write, single-port-read table with registered read data and an
// equality match against a key.
// ----------------------------------------------------------------------------
module prt_table #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    input  logic [WIDTH-1:0] key,
    output logic             match
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= rd_en;
        end
    end

    assign match = rd_vld_reg && (rd_data_reg == key);

endmodule

/* rtl/prt_least.sv */
// ----------------------------------------------------------------------------
// prt_least
// Running minimum of the ready ids and the parent-ready flag.
// ----------------------------------------------------------------------------
module prt_least (
    input  logic               clk,
    input  logic               rst_n,
    input  prt_pkg::least_ctl_t ctl,
    input  prt_pkg::id_t       key,
    output prt_pkg::id_t       least,
    output logic               ready_flag
);

    prt_pkg::id_t least_reg;
    prt_pkg::id_t least_next;
    logic         flag_reg;
    logic         flag_next;

    always_comb
    begin
        least_next = least_reg;
        flag_next  = flag_reg;
        if (ctl.clr)
        begin
            least_next = '0;
            flag_next  = 1'b0;
        end
        else if (ctl.upd)
        begin
            // slot first, then hash bytes: one unsigned compare on the packed id
            if (!flag_reg || (key < least_reg))
            begin
                least_next = key;
            end
            flag_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            least_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            least_reg <= least_next;
            flag_reg  <= flag_next;
        end
    end

    assign least      = least_reg;
    assign ready_flag = flag_reg;

endmodule

/* verif/prt_reply_check.sv */
// ----------------------------------------------------------------------------
// prt_reply_check
// Watches both stream channels of the parent-ready tracker table, tracks its
// skip flag, fallback set and ready list, and compares every result
// transaction against the reply owed for the oldest outstanding request.
// ----------------------------------------------------------------------------
module prt_reply_check #(
    parameter int TABLE_CAP = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // entry_slot, hash_word0, hash_word1, hash_word2, hash_word3
    input  logic [319:0] s_tdata,
    // func
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    // accepted, error_code, parent_ready, best_slot, best_hash_word0,
    // best_hash_word1, best_hash_word2, best_hash_word3, 4 bits zero pad
    input  logic [327:0] m_tdata,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                       accepted;
        logic [prt_pkg::ERR_W-1:0]  error_code;
        logic                       parent_ready;
        logic [prt_pkg::SLOT_W-1:0] best_slot;
        prt_pkg::hash_t             best_hash;
    } reply_t;

    reply_t                     replies_owed[$];
    reply_t                     cur;

    logic                       skip_set;
    prt_pkg::hash_t             fb_hashes [TABLE_CAP];
    int                         fb_count;
    logic [prt_pkg::SLOT_W-1:0] rdy_slots [TABLE_CAP];
    prt_pkg::hash_t             rdy_hashes [TABLE_CAP];
    int                         rdy_count;
    logic                       parent_seen;
    logic [prt_pkg::SLOT_W-1:0] least_slot;
    prt_pkg::hash_t             least_hash;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic clear_tracker();
        skip_set    = 1'b0;
        fb_count    = 0;
        rdy_count   = 0;
        parent_seen = 1'b0;
        least_slot  = '0;
        least_hash  = '0;
    endtask

    // Apply one request to the tracked state and return the reply it owes.
    task automatic track_request(input logic [prt_pkg::FUNC_W-1:0] op,
                                 input logic [prt_pkg::SLOT_W-1:0] slot,
                                 input prt_pkg::hash_t h, output reply_t r);
        bit dup;
        dup          = 1'b0;
        r.accepted   = 1'b0;
        r.error_code = prt_pkg::ERR_NONE;
        case (op)
            prt_pkg::FUNC_INIT:
                clear_tracker();
            prt_pkg::FUNC_GENESIS:
            begin
                clear_tracker();
                fb_hashes[0] = '0;
                fb_count     = 1;
            end
            prt_pkg::FUNC_SKIP:
            begin
                if (!skip_set)
                begin
                    skip_set   = 1'b1;
                    r.accepted = 1'b1;
                end
            end
            prt_pkg::FUNC_FALLBACK:
            begin
                for (int i = 0; i < fb_count; i++)
                    if (fb_hashes[i] == h)
                        dup = 1'b1;
                // a repeated fallback hash is silently dropped
                if (!dup)
                begin
                    if (fb_count >= TABLE_CAP)
                        r.error_code = prt_pkg::ERR_FB_FULL;
                    else
                    begin
                        fb_hashes[fb_count] = h;
                        fb_count++;
                        r.accepted = 1'b1;
                    end
                end
            end
            prt_pkg::FUNC_ADD:
            begin
                for (int i = 0; i < rdy_count; i++)
                    if (rdy_slots[i] == slot && rdy_hashes[i] == h)
                        dup = 1'b1;
                // duplicate check wins over the full check
                if (dup)
                    r.error_code = prt_pkg::ERR_DUP;
                else if (rdy_count >= TABLE_CAP)
                    r.error_code = prt_pkg::ERR_RDY_FULL;
                else
                begin
                    rdy_slots[rdy_count]  = slot;
                    rdy_hashes[rdy_count] = h;
                    rdy_count++;
                    // word 0 sits on top, so one unsigned compare orders slot then bytes
                    if (!parent_seen || {slot, h} < {least_slot, least_hash})
                    begin
                        least_slot = slot;
                        least_hash = h;
                    end
                    parent_seen = 1'b1;
                    r.accepted  = 1'b1;
                end
            end
            prt_pkg::FUNC_QUERY:
                r.accepted = parent_seen;
            default:
                ;
        endcase
        r.parent_ready = parent_seen;
        r.best_slot    = parent_seen ? least_slot : '0;
        r.best_hash    = parent_seen ? least_hash : '0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_tracker();
            replies_owed.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            // retire the result first so a same-edge request cannot cover for it
            if (m_tvalid && m_tready)
            begin
                if (replies_owed.size() == 0)
                    report_mismatch("result transaction with no request outstanding",
                                    64'(m_tdata[3:0]), '0);
                else
                begin
                    cur = replies_owed.pop_front();
                    check_field("accepted", 64'(m_tdata[0]), 64'(cur.accepted));
                    check_field("error_code", 64'(m_tdata[2:1]), 64'(cur.error_code));
                    check_field("parent_ready", 64'(m_tdata[3]), 64'(cur.parent_ready));
                    check_field("best_slot", m_tdata[67:4], cur.best_slot);
                    check_field("best_hash_word0", m_tdata[131:68], cur.best_hash[255:192]);
                    check_field("best_hash_word1", m_tdata[195:132], cur.best_hash[191:128]);
                    check_field("best_hash_word2", m_tdata[259:196], cur.best_hash[127:64]);
                    check_field("best_hash_word3", m_tdata[323:260], cur.best_hash[63:0]);
                end
            end
            if (s_tvalid && s_tready)
            begin
                track_request(s_tuser, s_tdata[63:0],
                              {s_tdata[127:64], s_tdata[191:128],
                               s_tdata[255:192], s_tdata[319:256]}, cur);
                replies_owed.push_back(cur);
            end
            pending = replies_owed.size();
        end
    end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives the parent-ready tracker table with a directed opening and then
// random request sessions (mostly opened by init or genesis, followed by adds,
// fallbacks, skips, queries and spare codes over small id pools or table-filling
// fresh ids), with random idling and back-pressure; prt_reply_check does the checking.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP          = 16;
    localparam int ITEM_TARGET  = 2000;
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 24;

    // codes the block ignores
    localparam logic [prt_pkg::FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
    localparam logic [prt_pkg::FUNC_W-1:0] FUNC_SPARE_B = 3'd7;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [319:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [327:0] m_tdata;
    int           fail_count;
    int           pending;

    bit                         calm_tx;
    bit                         fill_mode;
    logic [prt_pkg::SLOT_W-1:0] slot_pool [4];
    prt_pkg::hash_t             hash_pool [4];

    parent_ready_tracker_table #(
        .TABLE_CAP(CAP)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    prt_reply_check #(
        .TABLE_CAP(CAP)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic prt_pkg::hash_t rand_hash();
        return {rand64(), rand64(), rand64(), rand64()};
    endfunction

    function automatic logic [prt_pkg::SLOT_W-1:0] pick_slot();
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return fill_mode ? rand64() : slot_pool[$urandom_range(0, 3)];
            default:    return rand64();
        endcase
    endfunction

    function automatic prt_pkg::hash_t pick_hash();
        case ($urandom_range(0, 9))
            0:             return '0;
            1:             return '1;
            2, 3, 4, 5, 6: return fill_mode ? rand_hash() : hash_pool[$urandom_range(0, 3)];
            default:       return rand_hash();
        endcase
    endfunction

    // Pools of near-equal ids: mostly neighbouring slots and hashes that differ in one word.
    task automatic refresh_pools();
        prt_pkg::hash_t base;
        base         = rand_hash();
        slot_pool[0] = rand64();
        slot_pool[1] = slot_pool[0] + 1;
        slot_pool[2] = 64'($urandom_range(0, 15));
        slot_pool[3] = slot_pool[0] - 1;
        for (int k = 0; k < 4; k++)
        begin
            hash_pool[k] = base;
            if (k != 0)
                hash_pool[k][64 * $urandom_range(0, 3) +: 64] = rand64();
        end
    endtask

    task automatic send(input logic [prt_pkg::FUNC_W-1:0] op,
                        input logic [prt_pkg::SLOT_W-1:0] slot,
                        input prt_pkg::hash_t h);
        while (!calm_tx && $urandom_range(0, 99) < 10)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {h[63:0], h[127:64], h[191:128], h[255:192], slot};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Result side: random stalls, one long hold-off, one calm stretch.
    initial
    begin
        int got;
        int hold_left;
        bit held;
        got       = 0;
        hold_left = 0;
        held      = 1'b0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                got++;
            if (!held && got >= 600)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= (got >= 1200 && got < 1500) || $urandom_range(0, 99) >= 10;
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        int                         sent;
        int                         r;
        int                         run_len;
        bit                         drained;
        logic [prt_pkg::FUNC_W-1:0] op;
        logic [prt_pkg::FUNC_W-1:0] fill_op;
        sent      = 0;
        drained   = 1'b0;
        calm_tx   = 1'b0;
        fill_mode = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= prt_pkg::FUNC_INIT;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening
        send(prt_pkg::FUNC_QUERY, '0, '0);
        send(prt_pkg::FUNC_SKIP, '1, '1);
        send(prt_pkg::FUNC_SKIP, '0, '0);
        send(prt_pkg::FUNC_FALLBACK, '0, '1);
        send(prt_pkg::FUNC_FALLBACK, '1, '1);
        send(prt_pkg::FUNC_ADD, '1, '1);
        send(prt_pkg::FUNC_ADD, '0, '1);
        send(prt_pkg::FUNC_ADD, '0, '0);
        send(prt_pkg::FUNC_ADD, '0, '0);
        send(prt_pkg::FUNC_ADD, '0, {64'h0, 64'h0, 64'h0, 64'h1});
        send(prt_pkg::FUNC_ADD, 64'h1, '0);
        send(prt_pkg::FUNC_QUERY, '1, '1);
        send(FUNC_SPARE_A, '1, '1);
        send(FUNC_SPARE_B, '0, '0);
        send(prt_pkg::FUNC_GENESIS, '1, '1);
        send(prt_pkg::FUNC_FALLBACK, '0, '0);
        send(prt_pkg::FUNC_FALLBACK, '0, {64'h8000_0000_0000_0000, 64'h0, 64'h0, 64'h0});
        send(prt_pkg::FUNC_QUERY, '0, '0);
        send(prt_pkg::FUNC_ADD, 64'h5, {4{64'haaaa_5555_aaaa_5555}});
        send(prt_pkg::FUNC_QUERY, '0, '0);
        send(prt_pkg::FUNC_INIT, '1, '1);
        send(prt_pkg::FUNC_QUERY, '0, '0);
        send(prt_pkg::FUNC_SKIP, '0, '0);

        // random sessions
        while (sent < ITEM_TARGET)
        begin
            fill_mode = ($urandom_range(0, 3) == 0);
            fill_op   = $urandom_range(0, 1) ? prt_pkg::FUNC_ADD : prt_pkg::FUNC_FALLBACK;
            refresh_pools();
            r = $urandom_range(0, 9);
            if (r < 5)
            begin
                send(prt_pkg::FUNC_INIT, rand64(), rand_hash());
                sent++;
            end
            else if (r < 9)
            begin
                send(prt_pkg::FUNC_GENESIS, rand64(), rand_hash());
                sent++;
            end
            run_len = fill_mode ? $urandom_range(36, 48) : $urandom_range(8, 40);
            for (int n = 0; n < run_len; n++)
            begin
                calm_tx = (sent >= 1200 && sent < 1500);
                if (!drained && sent >= 1000)
                begin
                    // hold until every owed result is back
                    drained = 1'b1;
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0)
                        @(posedge clk);
                end
                r = $urandom_range(0, 99);
                if (fill_mode && $urandom_range(0, 99) < 60)
                    op = fill_op;
                else if (r < 45)
                    op = prt_pkg::FUNC_ADD;
                else if (r < 68)
                    op = prt_pkg::FUNC_FALLBACK;
                else if (r < 76)
                    op = prt_pkg::FUNC_SKIP;
                else if (r < 94)
                    op = prt_pkg::FUNC_QUERY;
                else
                    op = r[0] ? FUNC_SPARE_A : FUNC_SPARE_B;
                send(op, pick_slot(), pick_hash());
                if (op != FUNC_SPARE_A && op != FUNC_SPARE_B)
                    sent++;
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
